@@ sv/uer_pkg.sv @@
package uer_pkg;

	// measurement sequencer phases
	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_LEAD = 6'b000010,
		PH_HIGH = 6'b000100,
		PH_TAIL = 6'b001000,
		PH_WAIT = 6'b010000,
		PH_MEAS = 6'b100000
	} phase_t;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_NO_OBST = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_LEAD_LOW   = 3'd0;
	localparam logic [2:0] REG_PULSE_HIGH = 3'd1;
	localparam logic [2:0] REG_TAIL_LOW   = 3'd2;
	localparam logic [2:0] REG_RISE_WAIT  = 3'd3;
	localparam logic [2:0] REG_MAX_WIDTH  = 3'd4;

	// register reset values
	localparam logic [7:0]  LEAD_LOW_RST   = 8'd10;
	localparam logic [7:0]  PULSE_HIGH_RST = 8'd15;
	localparam logic [7:0]  TAIL_LOW_RST   = 8'd20;
	localparam logic [19:0] RISE_WAIT_RST  = 20'd600000;
	localparam logic [15:0] MAX_WIDTH_RST  = 16'd60000;

	// ticks per centimeter of round trip
	localparam logic [5:0] CM_DIVISOR = 6'd58;

	// one result transfer
	typedef struct packed {
		logic        trigger_level;
		logic        busy_res;
		logic        done_res;
		logic [1:0]  status;
		logic [15:0] pulse_ticks;
		logic [10:0] distance_cm;
	} res_t;

endpackage

@@ sv/ultrasonic_echo_ranger_top.sv @@
// Ultrasonic echo ranger. Each input transfer is one 1 us timer tick carrying a command
// (plain tick or start) and the sampled echo pin level; each input transfer yields exactly
// one result transfer, in order. A start runs one measurement: the trigger pin is driven
// low, high and low for the configured tick counts, then the block waits for the echo to
// rise (timeout status after rise_wait_limit ticks) and counts the ticks the echo stays
// high. A width above max_width_ticks reports no obstacle; otherwise the width and the
// distance in cm (width / 58, floor) are reported and held until the next finish. Rate is
// one item per clock cycle while in_stall is low: the sequencer state advances in the cycle
// an item is taken and the result is registered. A two-entry output buffer (result register
// plus skid register) lets an item be taken while a result still waits; input stall rises
// only when both entries are full. The distance comes from a quotient/remainder counter
// pair kept alongside the width count, so no divider or multiplier sits in the tick path.
// Start commands while busy are ignored. Configuration writes are meant for idle periods
// only.
module ultrasonic_echo_ranger_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic        echo_level,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        trigger_level,
	output logic        busy_res,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [15:0] pulse_ticks,
	output logic [10:0] distance_cm
);
	import uer_pkg::*;

	// configuration registers
	logic [7:0]  lead_low_q, pulse_high_q, tail_low_q;
	logic [19:0] rise_wait_q;
	logic [15:0] max_width_q;

	// sequencer state
	phase_t      phase_q;
	logic [19:0] phase_cnt_q;
	logic [16:0] width_cnt_q;
	logic [10:0] quo_q;     // width_cnt_q / 58, kept incrementally
	logic [5:0]  rem_q;     // width_cnt_q % 58

	// last finished measurement
	logic [1:0]  held_status_q;
	logic [15:0] held_width_q;
	logic [10:0] held_dist_q;

	// output buffer: result register and skid register
	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	// next-state signals
	phase_t      phase_cur, phase_d;
	logic [19:0] cnt_cur, cnt_inc, phase_cnt_d;
	logic [16:0] width_inc, width_cnt_d;
	logic [10:0] quo_inc, quo_d;
	logic [5:0]  rem_inc, rem_d;
	logic [1:0]  held_status_d;
	logic [15:0] held_width_d;
	logic [10:0] held_dist_d;
	logic        start, trig, done;
	res_t        res_new;

	logic in_fire, out_fire;

	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !skid_valid_q;
	assign out_fire = out_valid_q && !out_stall;

	// configuration writes, values masked to register width by the slices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_low_q   <= LEAD_LOW_RST;
			pulse_high_q <= PULSE_HIGH_RST;
			tail_low_q   <= TAIL_LOW_RST;
			rise_wait_q  <= RISE_WAIT_RST;
			max_width_q  <= MAX_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEAD_LOW:   lead_low_q   <= cfg_data[7:0];
				REG_PULSE_HIGH: pulse_high_q <= cfg_data[7:0];
				REG_TAIL_LOW:   tail_low_q   <= cfg_data[7:0];
				REG_RISE_WAIT:  rise_wait_q  <= cfg_data;
				REG_MAX_WIDTH:  max_width_q  <= cfg_data[15:0];
				default: ;      // unused indexes are ignored
			endcase
		end
	end

	// one tick of the sequencer
	always_comb begin
		// a start in idle enters lead-low and runs its first tick right away
		start     = (phase_q == PH_IDLE) && command;
		phase_cur = start ? PH_LEAD : phase_q;
		cnt_cur   = start ? 20'd0 : phase_cnt_q;
		cnt_inc   = cnt_cur + 20'd1;
		width_inc = width_cnt_q + 17'd1;
		// quotient/remainder follow width_inc
		if (rem_q == CM_DIVISOR - 6'd1) begin
			rem_inc = 6'd0;
			quo_inc = quo_q + 11'd1;
		end else begin
			rem_inc = rem_q + 6'd1;
			quo_inc = quo_q;
		end

		phase_d       = phase_cur;
		phase_cnt_d   = cnt_cur;
		width_cnt_d   = start ? 17'd0 : width_cnt_q;
		quo_d         = start ? 11'd0 : quo_q;
		rem_d         = start ? 6'd0 : rem_q;
		held_status_d = held_status_q;
		held_width_d  = held_width_q;
		held_dist_d   = held_dist_q;
		trig          = 1'b0;
		done          = 1'b0;

		case (phase_cur)
			PH_LEAD: begin
				phase_cnt_d = cnt_inc;
				if (cnt_inc >= {12'd0, lead_low_q}) begin
					phase_d     = PH_HIGH;
					phase_cnt_d = 20'd0;
				end
			end
			PH_HIGH: begin
				trig        = 1'b1;
				phase_cnt_d = cnt_inc;
				if (cnt_inc >= {12'd0, pulse_high_q}) begin
					phase_d     = PH_TAIL;
					phase_cnt_d = 20'd0;
				end
			end
			PH_TAIL: begin
				phase_cnt_d = cnt_inc;
				if (cnt_inc >= {12'd0, tail_low_q}) begin
					phase_d     = PH_WAIT;
					phase_cnt_d = 20'd0;
				end
			end
			PH_WAIT: begin
				if (echo_level) begin
					// rising tick starts the width count at zero
					phase_d     = PH_MEAS;
					width_cnt_d = 17'd0;
					quo_d       = 11'd0;
					rem_d       = 6'd0;
				end else begin
					phase_cnt_d = cnt_inc;
					if (cnt_inc >= rise_wait_q) begin
						phase_d       = PH_IDLE;
						phase_cnt_d   = 20'd0;
						held_status_d = ST_TIMEOUT;
						held_width_d  = 16'd0;
						held_dist_d   = 11'd0;
						done          = 1'b1;
					end
				end
			end
			PH_MEAS: begin
				width_cnt_d = width_inc;
				quo_d       = quo_inc;
				rem_d       = rem_inc;
				if (width_inc > {1'b0, max_width_q}) begin
					// echo too long: no obstacle
					phase_d       = PH_IDLE;
					phase_cnt_d   = 20'd0;
					held_status_d = ST_NO_OBST;
					held_width_d  = 16'd0;
					held_dist_d   = 11'd0;
					done          = 1'b1;
				end else if (!echo_level) begin
					// falling tick closes the count; width fits 16 bits here
					phase_d       = PH_IDLE;
					phase_cnt_d   = 20'd0;
					held_status_d = ST_OK;
					held_width_d  = width_inc[15:0];
					held_dist_d   = quo_inc;
					done          = 1'b1;
				end
			end
			default: ;      // idle without start: nothing moves
		endcase

		res_new.trigger_level = trig;
		res_new.busy_res      = (phase_d != PH_IDLE);
		res_new.done_res      = done;
		res_new.status        = held_status_d;
		res_new.pulse_ticks   = held_width_d;
		res_new.distance_cm   = held_dist_d;
	end

	// state advances once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			phase_cnt_q   <= 20'd0;
			width_cnt_q   <= 17'd0;
			quo_q         <= 11'd0;
			rem_q         <= 6'd0;
			held_status_q <= ST_OK;
			held_width_q  <= 16'd0;
			held_dist_q   <= 11'd0;
		end else if (in_fire) begin
			phase_q       <= phase_d;
			phase_cnt_q   <= phase_cnt_d;
			width_cnt_q   <= width_cnt_d;
			quo_q         <= quo_d;
			rem_q         <= rem_d;
			held_status_q <= held_status_d;
			held_width_q  <= held_width_d;
			held_dist_q   <= held_dist_d;
		end
	end

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// input is stalled; drain skid into the result register
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (in_fire) begin
			if (out_valid_q && !out_fire) begin
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign trigger_level = out_q.trigger_level;
	assign busy_res      = out_q.busy_res;
	assign done_res      = out_q.done_res;
	assign status        = out_q.status;
	assign pulse_ticks   = out_q.pulse_ticks;
	assign distance_cm   = out_q.distance_cm;

endmodule
